// File: sv/sbd_pkg.sv
// Shared constants and types for the signed base-b digit decomposition core.
`default_nettype none
package sbd_pkg;

  localparam int VALUE_W    = 64;
  localparam int BASE_W     = 17;
  localparam int COUNT_W    = 7;
  localparam int DIGIT_W    = 17;
  localparam int MAX_DIGITS = 64;
  localparam int STEP_W     = $clog2(VALUE_W);
  localparam int K_W        = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CFG_IDX_W  = 1;

  localparam logic [BASE_W-1:0]  BASE_MIN  = BASE_W'(2);
  localparam logic [BASE_W-1:0]  BASE_MAX  = BASE_W'(65536);
  localparam logic [COUNT_W-1:0] COUNT_MIN = COUNT_W'(1);
  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_DIGITS);

  localparam logic [BASE_W-1:0]  BASE_RST  = BASE_W'(2);
  localparam logic [COUNT_W-1:0] COUNT_RST = COUNT_W'(8);

  localparam logic [CFG_IDX_W-1:0] CFG_BASE        = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_COUNT = CFG_IDX_W'(1);

  typedef struct packed {
    logic busy;
    logic done;
  } sbd_div_stat_t;

endpackage
`default_nettype wire

// File: sv/sbd_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle over the full value width.
`default_nettype none
module sbd_divider
  import sbd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [VALUE_W-1:0] dividend,
  input  wire logic [BASE_W-1:0]  divisor,
  output sbd_div_stat_t           stat,
  output logic      [VALUE_W-1:0] quotient,
  output logic      [BASE_W-1:0]  remainder
);

  logic [VALUE_W-1:0] q_r;
  logic [BASE_W-1:0]  rem_r;
  logic [STEP_W-1:0]  cnt_r;
  logic               busy_r;
  logic               done_r;

  logic [BASE_W:0] trial;
  logic [BASE_W:0] diff;
  logic            ge;

  // Bring down the next dividend bit beside the partial remainder.
  always_comb begin
    trial = {rem_r, q_r[VALUE_W-1]};
    diff  = trial - {1'b0, divisor};
    ge    = (trial >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + STEP_W'(1);
        if (cnt_r == STEP_W'(VALUE_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      q_r   <= {q_r[VALUE_W-2:0], ge};
      // Partial remainder stays below the divisor, so it fits the base width.
      rem_r <= ge ? diff[BASE_W-1:0] : trial[BASE_W-1:0];
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

// File: sv/signed_base_b_digit_decompose_core.sv
// Top level: configuration, digit sequencing and output register of the decomposition core.
// Each accepted value yields digit_count signed digits, least significant first, the last one
// flagged. Every digit comes from a bit-serial divider that retires one quotient bit per
// cycle, and the next digit's divider run starts when a digit is loaded into the output
// register. A new value is taken only in idle, once the last digit of the previous value has
// been loaded; a digit waits in place while the output register is full. Base is clamped to
// 2..65536 and digit_count to 1..64 when a value is taken; magnitude above base^digit_count
// is dropped without notice.
`default_nettype none
module signed_base_b_digit_decompose_core
  import sbd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BASE_W-1:0]    cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic signed [VALUE_W-1:0] in_value,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [DIGIT_W-1:0] out_digit,
  output logic                      out_last
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [BASE_W-1:0]  base_r;
  logic [COUNT_W-1:0] count_r;
  logic [BASE_W-1:0]  base_eff_r;
  logic [COUNT_W-1:0] count_eff_r;
  logic               neg_r;
  logic [K_W-1:0]     k_r;

  logic                 out_valid_r;
  logic [DIGIT_W-1:0]   out_digit_r;
  logic                 out_last_r;

  sbd_div_stat_t      div_stat;
  logic [VALUE_W-1:0] div_q;
  logic [BASE_W-1:0]  div_rem;
  logic [VALUE_W-1:0] div_dividend;
  logic               div_start;

  logic               accept;
  logic               slot_free;
  logic               pending;
  logic               load_out;
  logic               is_last;
  logic [VALUE_W-1:0] mag;
  logic [BASE_W-1:0]  base_clamped;
  logic [COUNT_W-1:0] count_clamped;
  logic [DIGIT_W-1:0] digit_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= BASE_RST;
      count_r <= COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BASE:        base_r  <= cfg_data;
        CFG_DIGIT_COUNT: count_r <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (base_r < BASE_MIN) begin
      base_clamped = BASE_MIN;
    end else if (base_r > BASE_MAX) begin
      base_clamped = BASE_MAX;
    end else begin
      base_clamped = base_r;
    end
    if (count_r < COUNT_MIN) begin
      count_clamped = COUNT_MIN;
    end else if (count_r > COUNT_MAX) begin
      count_clamped = COUNT_MAX;
    end else begin
      count_clamped = count_r;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign mag       = in_value[VALUE_W-1] ? (VALUE_W'(0) - in_value) : in_value;
  assign slot_free = !out_valid_r || out_ready;
  assign pending   = ((state_r == ST_DIV) && div_stat.done) || (state_r == ST_HOLD);
  assign load_out  = pending && slot_free;
  assign is_last   = ((COUNT_W'(k_r) + COUNT_W'(1)) == count_eff_r);
  assign div_start = accept || (load_out && !is_last);
  // Feed the previous quotient back for the next digit.
  assign div_dividend = accept ? mag : div_q;
  assign digit_val    = neg_r ? (DIGIT_W'(0) - DIGIT_W'(div_rem)) : DIGIT_W'(div_rem);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          if (!slot_free) state_nxt = ST_HOLD;
          else if (is_last) state_nxt = ST_IDLE;
        end
      end
      ST_HOLD: begin
        if (slot_free) state_nxt = is_last ? ST_IDLE : ST_DIV;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        k_r <= '0;
      end else if (load_out && !is_last) begin
        k_r <= k_r + K_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      neg_r       <= in_value[VALUE_W-1];
      base_eff_r  <= base_clamped;
      count_eff_r <= count_clamped;
    end
    if (load_out) begin
      out_digit_r <= digit_val;
      out_last_r  <= is_last;
    end
  end

  sbd_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (base_eff_r),
    .stat      (div_stat),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  assign out_valid = out_valid_r;
  assign out_digit = out_digit_r;
  assign out_last  = out_last_r;

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == ST_DIV))
    else $error("divider finished outside a digit step");

  a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (COUNT_W'(k_r) < count_eff_r))
    else $error("digit index ran past the digit count");

  a_rem_below_base: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (div_rem < base_eff_r))
    else $error("digit not below the base");

  a_no_start_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("second value taken while a run is in progress");

endmodule
`default_nettype wire

// File: tb/signed_base_b_digit_decompose_core_tb.sv
// Self-checking testbench for the signed base-b digit decomposition core.
`timescale 1ns / 100ps
module signed_base_b_digit_decompose_core_tb
  import sbd_pkg::*;
;

  localparam int CYCLE_LIMIT  = 5_000_000;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 150;
  localparam int IDLE_HEAVY   = 84;
  localparam int IDLE_LIGHT   = 26;
  localparam int FIXED_DIGITS = 8;

  localparam logic [VALUE_W-1:0] MOST_NEG = 64'h8000_0000_0000_0000;
  localparam logic [VALUE_W-1:0] MOST_POS = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic signed [DIGIT_W-1:0] digit;
    logic                      last;
  } digit_beat_t;

  typedef enum logic {ROW_REGS, ROW_VALUE} row_kind_t;

  typedef struct packed {
    row_kind_t                                 kind;
    logic [BASE_W-1:0]                         base_data;
    logic [BASE_W-1:0]                         count_data;
    logic [VALUE_W-1:0]                        value;
    logic                                      fixed;
    logic [FIXED_DIGITS-1:0][DIGIT_W-1:0]      digits;   // [0] is least significant
  } dir_row_t;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [BASE_W-1:0]         cfg_data;
  logic                      in_valid;
  logic                      in_ready;
  logic [VALUE_W-1:0]        in_value;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [DIGIT_W-1:0] out_digit;
  logic                      out_last;

  logic [BASE_W-1:0]  base_reg;
  logic [COUNT_W-1:0] count_reg;
  digit_beat_t        digits_q[$];
  digit_beat_t        seen_beat;
  dir_row_t           dir_tbl[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  logic hold_req  = 1'b0;
  logic hold_done = 1'b0;
  int hold_count  = 0;
  int cycle_count = 0;
  int mismatches  = 0;
  int values_sent = 0;
  int digits_checked = 0;
  int regs_written   = 0;

  signed_base_b_digit_decompose_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_value  (in_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_digit (out_digit),
    .out_last  (out_last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) begin
      $display("[%0t] MISMATCH: %s", $time, msg);
    end
  endtask

  function automatic logic [VALUE_W-1:0] eff_base();
    if (base_reg < BASE_MIN) begin
      return VALUE_W'(BASE_MIN);
    end
    if (base_reg > BASE_MAX) begin
      return VALUE_W'(BASE_MAX);
    end
    return VALUE_W'(base_reg);
  endfunction

  function automatic int run_length();
    if (count_reg < COUNT_MIN) begin
      return int'(COUNT_MIN);
    end
    if (count_reg > COUNT_MAX) begin
      return int'(COUNT_MAX);
    end
    return int'(count_reg);
  endfunction

  // Peel digits off the magnitude, least significant first, carrying the input sign.
  task automatic predict_digits(input logic [VALUE_W-1:0] v);
    logic               neg;
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] b;
    logic [VALUE_W-1:0] rem;
    logic [VALUE_W-1:0] d;
    digit_beat_t        beat;
    int                 n;
    neg = v[VALUE_W-1];
    mag = neg ? (64'd0 - v) : v;
    b   = eff_base();
    n   = run_length();
    for (int k = 0; k < n; k++) begin
      rem = mag % b;
      mag = mag / b;
      d   = neg ? (64'd0 - rem) : rem;
      beat.digit = d[DIGIT_W-1:0];
      beat.last  = (k == n - 1);
      digits_q.push_back(beat);
    end
  endtask

  task automatic program_regs(input logic [BASE_W-1:0] b, input logic [BASE_W-1:0] c);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BASE;
    cfg_data  <= b;
    @(posedge clk);
    base_reg   = b;
    cfg_index <= CFG_DIGIT_COUNT;
    cfg_data  <= c;
    @(posedge clk);
    count_reg = c[COUNT_W-1:0];
    cfg_we   <= 1'b0;
    regs_written++;
  endtask

  // Returns at the edge that accepts the beat; valid is left high for a following beat.
  task automatic send_value(input logic [VALUE_W-1:0] v, input logic fixed,
                            input logic [FIXED_DIGITS-1:0][DIGIT_W-1:0] fixed_digits);
    digit_beat_t beat;
    int          n;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (fixed) begin
      n = run_length();
      for (int k = 0; k < n; k++) begin
        beat.digit = fixed_digits[k];
        beat.last  = (k == n - 1);
        digits_q.push_back(beat);
      end
    end else begin
      predict_digits(v);
    end
    values_sent++;
  endtask

  // Drop valid and wait for every digit in flight to come out.
  task automatic settle();
    in_valid <= 1'b0;
    while (digits_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic dir_row_t regs_row(input logic [BASE_W-1:0] b,
                                        input logic [BASE_W-1:0] c);
    dir_row_t r;
    r = '0;
    r.kind       = ROW_REGS;
    r.base_data  = b;
    r.count_data = c;
    return r;
  endfunction

  function automatic dir_row_t value_row(input logic [VALUE_W-1:0] v);
    dir_row_t r;
    r = '0;
    r.kind  = ROW_VALUE;
    r.value = v;
    return r;
  endfunction

  function automatic dir_row_t fixed_row(input logic [VALUE_W-1:0] v,
                                         input logic [FIXED_DIGITS-1:0][DIGIT_W-1:0] d);
    dir_row_t r;
    r = value_row(v);
    r.fixed  = 1'b1;
    r.digits = d;
    return r;
  endfunction

  function automatic logic [BASE_W-1:0] pick_base();
    case ($urandom_range(9, 0))
      0:       return BASE_W'($urandom_range(1, 0));
      1:       return BASE_MAX;
      2:       return BASE_W'($urandom_range(131071, 65537));
      3:       return BASE_MIN;
      4, 5, 6: return BASE_W'($urandom_range(16, 2));
      default: return BASE_W'($urandom_range(65536, 2));
    endcase
  endfunction

  // Upper data bits are noise; only the low field reaches the register.
  function automatic logic [BASE_W-1:0] pick_count();
    logic [BASE_W-1:0] d;
    d = BASE_W'($urandom);
    case ($urandom_range(19, 0))
      0:       d[COUNT_W-1:0] = '0;
      1:       d[COUNT_W-1:0] = COUNT_W'($urandom_range(127, 64));
      default: d[COUNT_W-1:0] = COUNT_W'($urandom_range(6, 1));
    endcase
    return d;
  endfunction

  function automatic logic [VALUE_W-1:0] rand_value();
    logic [VALUE_W-1:0] v;
    logic [VALUE_W-1:0] p;
    case ($urandom_range(5, 0))
      0, 1: v = {$urandom, $urandom};
      2:    v = VALUE_W'($urandom_range(65535, 0));
      3: begin
        // land near a power of the base to exercise digit carries and drops
        p = 64'd1;
        repeat ($urandom_range(4, 1)) p = p * eff_base();
        v = p + VALUE_W'($urandom_range(2, 0)) - 64'd1;
      end
      4: begin
        case ($urandom_range(3, 0))
          0:       v = MOST_NEG;
          1:       v = MOST_POS;
          2:       v = '0;
          default: v = 64'd1;
        endcase
      end
      default: v = {32'd0, $urandom} >> $urandom_range(31, 0);
    endcase
    if ($urandom_range(1, 0) == 1) begin
      v = 64'd0 - v;
    end
    return v;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      // long hold-off so the core fills and back-pressures its input
      out_ready  <= 1'b0;
      hold_count <= hold_count + 1;
      if (hold_count == HOLD_CYCLES - 1) begin
        hold_done <= 1'b1;
      end
    end else begin
      out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (digits_q.size() == 0) begin
        report_mismatch($sformatf("digit %0d last %0b with nothing expected",
                                  out_digit, out_last));
      end else begin
        seen_beat = digits_q.pop_front();
        if (out_digit !== seen_beat.digit) begin
          report_mismatch($sformatf("digit %0d, expected %0d", out_digit, seen_beat.digit));
        end
        if (out_last !== seen_beat.last) begin
          report_mismatch($sformatf("last %0b, expected %0b (digit %0d)",
                                    out_last, seen_beat.last, seen_beat.digit));
        end
        digits_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d digits outstanding", cycle_count,
               digits_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int ph;
    int sub;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_BASE;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    in_value  <= '0;
    base_reg  = BASE_RST;
    count_reg = COUNT_RST;

    // Reset settings: base 2, eight digits.
    dir_tbl.push_back(fixed_row(64'd0, '0));
    dir_tbl.push_back(fixed_row(64'd255, {8{17'd1}}));
    dir_tbl.push_back(fixed_row(-64'sd255, {8{17'h1FFFF}}));
    dir_tbl.push_back(fixed_row(64'd256, '0));
    dir_tbl.push_back(fixed_row(MOST_POS, {8{17'd1}}));
    dir_tbl.push_back(fixed_row(MOST_NEG, '0));
    dir_tbl.push_back(value_row(-64'sd2));
    // Widest base, one digit.
    dir_tbl.push_back(regs_row(BASE_MAX, 17'd1));
    dir_tbl.push_back(fixed_row(-64'sd1, 136'(17'h1FFFF)));
    dir_tbl.push_back(fixed_row(64'd65535, 136'(17'h0FFFF)));
    dir_tbl.push_back(fixed_row(-64'sd65535, 136'(17'h10001)));
    dir_tbl.push_back(fixed_row(64'd65536, '0));
    // Base below two and zero count clamp up.
    dir_tbl.push_back(regs_row(17'd0, 17'd0));
    dir_tbl.push_back(fixed_row(64'd3, 136'(17'd1)));
    dir_tbl.push_back(fixed_row(-64'sd3, 136'(17'h1FFFF)));
    // Count above range clamps to the maximum run.
    dir_tbl.push_back(regs_row(17'd1, 17'd65));
    dir_tbl.push_back(value_row(MOST_NEG));
    dir_tbl.push_back(value_row(-64'sd81985529216486895));
    // Base above range clamps to 65536.
    dir_tbl.push_back(regs_row(17'h1FFFF, 17'd4));
    dir_tbl.push_back(fixed_row(64'h0004_0003_0002_0001,
                                136'({17'd4, 17'd3, 17'd2, 17'd1})));
    dir_tbl.push_back(value_row(-64'sh0004_0003_0002_0001));
    dir_tbl.push_back(value_row(MOST_NEG));
    dir_tbl.push_back(value_row(MOST_POS));
    dir_tbl.push_back(regs_row(17'd65537, 17'd127));
    dir_tbl.push_back(value_row(-64'sd1));
    dir_tbl.push_back(regs_row(17'd3, 17'd40));
    dir_tbl.push_back(value_row(64'd12345678901234));
    dir_tbl.push_back(value_row(-64'sd12345678901234));
    dir_tbl.push_back(regs_row(BASE_MAX, 17'd64));
    dir_tbl.push_back(value_row(MOST_NEG));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].kind == ROW_REGS) begin
        settle();
        program_regs(dir_tbl[i].base_data, dir_tbl[i].count_data);
      end else begin
        send_value(dir_tbl[i].value, dir_tbl[i].fixed, dir_tbl[i].digits);
      end
    end

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = IDLE_HEAVY;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = IDLE_HEAVY;
        end
        default: begin
          send_idle_pct  = IDLE_LIGHT;
          recv_stall_pct = IDLE_LIGHT;
        end
      endcase
      for (sub = 0; sub < 4; sub++) begin
        settle();
        program_regs(pick_base(), pick_count());
        if (ph == 3 && sub == 1) begin
          hold_req = 1'b1;
        end
        repeat (9) send_value(rand_value(), 1'b0, '0);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d values over %0d register settings, %0d digits compared,",
             values_sent, regs_written, digits_checked);
    $display("with idle and stall mixes on both sides and one long output hold-off.");
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
